>>> hdl/kmbfs_pkg.sv
// Package: payload structs, controller/datapath command and status types, sizes.
`default_nettype none
package kmbfs_pkg;

	localparam int ROWS = 64;
	localparam int ROW_AW = 6;
	localparam int CNT_W = 12;
	localparam logic [CNT_W-1:0] COUNT_MAX = 12'hFFF;

	typedef struct packed {
		logic [5:0] start_col;
		logic [5:0] start_row;
		logic [5:0] goal_col;
		logic [5:0] goal_row;
	} in_t;

	typedef struct packed {
		logic [11:0] move_count;
		logic        found;
		logic        off_board;
	} out_t;

	typedef struct packed {
		logic load;
		logic sweep_go;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic off;
		logic any;
		logic hit;
		logic sweep_done;
	} status_t;

endpackage
`default_nettype wire

>>> hdl/knight_min_moves_bfs_top.sv
// Top level: knight shortest-path search engine with APB register port.
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+----------------------------------
// in      | in  | in_valid / in_ready  | in_data (start/goal col,row)
// out     | out | out_valid / out_ready| out_data (move_count,found,off)
// cfg     | in  | psel/penable/pwrite  | paddr, pwdata -> board_side
//
// One query per transfer; the search runs level by level, each level a sweep
// over the row memories followed by a check state; off-board queries and
// start-on-goal queries finish at the first check, with no sweep.
// No clearing pass: the first level synthesises an empty visited map.
// Reset sets board_side to 8 and empties the control path.
// A finished result sits in the output register while the next query is taken;
// the engine only stalls when it finishes again before that result is taken.
`default_nettype none
module knight_min_moves_bfs_top #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire kmbfs_pkg::in_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output kmbfs_pkg::out_t       out_data,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import kmbfs_pkg::*;

	logic [6:0] board_side_q;
	cmd_t       cmd;
	status_t    sts;
	logic       ctl_valid;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {25'd0, board_side_q};

	// register 0 at byte address 0, aliased at addresses 1 to 3; address 4 and above is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_side_q <= 7'd8;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			board_side_q <= pwdata[6:0];
		end
	end

	assign ctl_valid = in_valid;

	kmbfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ctl_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kmbfs_dp #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.board_side (board_side_q),
		.in_data    (in_data),
		.cmd        (cmd),
		.sts        (sts),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

>>> hdl/kmbfs_ctrl.sv
// Controller state machine: query intake, level loop and result hand-off.
`default_nettype none
module kmbfs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire kmbfs_pkg::status_t sts,
	output kmbfs_pkg::cmd_t        cmd
);
	import kmbfs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       finish;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign finish    = sts.off || sts.hit || !sts.any;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (finish) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.sweep_go = 1'b1;
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.sweep_done) state_d = ST_CHECK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> hdl/kmbfs_dp.sv
// Datapath: row sweep over frontier/visited memories, level counter, result register.
`default_nettype none
module kmbfs_dp #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [6:0]         board_side,
	input  wire kmbfs_pkg::in_t     in_data,
	input  wire kmbfs_pkg::cmd_t    cmd,
	output kmbfs_pkg::status_t      sts,
	output kmbfs_pkg::out_t         out_data
);
	import kmbfs_pkg::*;

	localparam logic [6:0] SIDE_LIM = 7'(MAX_SIDE);

	logic [5:0]       sc_q, sr_q, gc_q, gr_q;
	logic [6:0]       side_q;
	logic [63:0]      mask_q;
	logic             off_q, any_q, hit_q, done_q;
	logic             first_q, rdb_q, busy_q;
	logic [CNT_W-1:0] level_q;
	logic [6:0]       cnt_q;
	logic             any_acc_q, hit_acc_q;
	logic             v_s1;
	logic [6:0]       a_s1;
	logic [63:0]      w0_q, w1_q, w2_q, w3_q;
	logic [63:0]      fmem0 [ROWS];
	logic [63:0]      fmem1 [ROWS];
	logic [63:0]      vmem  [ROWS];
	logic [63:0]      f0_rd, f1_rd, v_rd;
	out_t             out_q;

	logic [6:0]  side_eff;
	logic [6:0]  vaddr;
	logic [63:0] fin, vis_eff, nxt, vis_new, newf;
	logic        proc, last;
	logic [6:0]  t_row;
	logic [5:0]  t_idx;

	assign side_eff = (board_side > SIDE_LIM) ? SIDE_LIM : board_side;
	assign vaddr    = cnt_q - 7'd2;
	assign t_row    = a_s1 - 7'd2;
	assign t_idx    = t_row[5:0];
	assign proc     = v_s1 && (a_s1 >= 7'd2);
	assign last     = v_s1 && (a_s1 == side_q + 7'd1);

	always_comb begin
		if (a_s1 >= side_q) fin = '0;
		else if (first_q) fin = (a_s1[5:0] == sr_q) ? (64'd1 << sc_q) : '0;
		else fin = rdb_q ? f1_rd : f0_rd;
		vis_eff = first_q ? '0 : v_rd;
		nxt = (w1_q << 2) | (w1_q >> 2) | (w3_q << 2) | (w3_q >> 2)
		    | (w0_q << 1) | (w0_q >> 1) | (fin << 1) | (fin >> 1);
		vis_new = vis_eff | w2_q;
		newf = nxt & mask_q & ~vis_new;
	end

	// row memories: registered reads, one write each
	always_ff @(posedge clk) begin
		f0_rd <= fmem0[cnt_q[5:0]];
		f1_rd <= fmem1[cnt_q[5:0]];
		v_rd  <= vmem[vaddr[5:0]];
		if (proc && rdb_q) fmem0[t_idx] <= newf;
		if (proc && !rdb_q) fmem1[t_idx] <= newf;
		if (proc) vmem[t_idx] <= vis_new;
	end

	// query registers and window (payload)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sc_q <= in_data.start_col;
			sr_q <= in_data.start_row;
			gc_q <= in_data.goal_col;
			gr_q <= in_data.goal_row;
			side_q <= side_eff;
			mask_q <= (side_eff >= 7'd64) ? '1 : ((64'd1 << side_eff[5:0]) - 64'd1);
		end
		if (cmd.sweep_go) begin
			w0_q <= '0; w1_q <= '0; w2_q <= '0; w3_q <= '0;
		end else if (v_s1) begin
			w0_q <= w1_q; w1_q <= w2_q; w2_q <= w3_q; w3_q <= fin;
		end
		a_s1 <= cnt_q;
		if (cmd.out_load) begin
			out_q.move_count <= off_q ? '0 : level_q;
			out_q.found <= !off_q && hit_q;
			out_q.off_board <= off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 1'b0; any_q <= 1'b0; hit_q <= 1'b0; done_q <= 1'b0;
			first_q <= 1'b0; rdb_q <= 1'b0; busy_q <= 1'b0; v_s1 <= 1'b0;
			level_q <= '0; cnt_q <= '0; any_acc_q <= 1'b0; hit_acc_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1 <= busy_q;
			if (cmd.load) begin
				off_q <= (in_data.start_col >= side_eff) || (in_data.start_row >= side_eff)
				      || (in_data.goal_col >= side_eff) || (in_data.goal_row >= side_eff);
				any_q <= 1'b1;
				hit_q <= (in_data.start_col == in_data.goal_col)
				      && (in_data.start_row == in_data.goal_row);
				level_q <= '0;
				first_q <= 1'b1;
				rdb_q <= 1'b1;
			end
			if (cmd.sweep_go) begin
				cnt_q <= '0;
				busy_q <= 1'b1;
				any_acc_q <= 1'b0;
				hit_acc_q <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q == side_q + 7'd1) busy_q <= 1'b0;
				else cnt_q <= cnt_q + 7'd1;
			end
			if (proc) begin
				any_acc_q <= any_acc_q || (|newf);
				if (t_idx == gr_q) hit_acc_q <= newf[gc_q];
			end
			if (last) begin
				any_q <= any_acc_q || (|newf);
				hit_q <= (t_idx == gr_q) ? newf[gc_q] : hit_acc_q;
				if (level_q != COUNT_MAX) level_q <= level_q + 1'b1;
				rdb_q <= !rdb_q;
				first_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign sts.off = off_q;
	assign sts.any = any_q;
	assign sts.hit = hit_q;
	assign sts.sweep_done = done_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

>>> tb/sv/tb_knight_min_moves_bfs_top.sv
// Testbench for the knight shortest-path search engine.
`default_nettype none
module tb_knight_min_moves_bfs_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kmbfs_pkg::*;

	// Register map: board_side is index 0, byte address 0; index 1 does not exist.
	localparam logic [2:0] ADDR_BOARD_SIDE = 3'd0;
	localparam logic [2:0] ADDR_UNUSED     = 3'd4;

	// Knight move table, column then row offsets.
	localparam int STEP_DC [8] = '{-2, -1, 2, 1, -1, -2, 1, 2};
	localparam int STEP_DR [8] = '{-1, -2, -1, -2, 2, 1, 2, 1};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Model copy of the side register and the queue of outstanding answers.
	logic [6:0]  side_reg;
	out_t        pending_answers[$];
	int          n_errors;
	int          n_checked;
	int          n_sent;
	int          n_found;
	int          n_unreached;
	int          n_off;

	knight_min_moves_bfs_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Level-by-level search on row bitmaps; bit c of a row word is column c.
	function automatic out_t knight_distance(in_t q, logic [6:0] side_raw);
		out_t        res;
		int          side;
		logic [63:0] mask;
		logic [63:0] seen[64];
		logic [63:0] front[64];
		logic [63:0] grow[64];
		logic [63:0] any;
		logic [63:0] w;
		logic [11:0] levels;
		logic        hit;
		int          tr;
		side = (side_raw > 7'd64) ? 64 : int'(side_raw);
		mask = (side >= 64) ? '1 : ((64'd1 << side) - 64'd1);
		res = '0;
		// off the board (this also covers a zero side): no search at all
		if (q.start_col >= side || q.start_row >= side ||
		    q.goal_col >= side || q.goal_row >= side) begin
			res.off_board = 1'b1;
			return res;
		end
		for (int r = 0; r < 64; r++) begin
			seen[r] = '0;
			front[r] = '0;
		end
		front[q.start_row] = 64'd1 << q.start_col;
		levels = '0;
		hit = 1'b0;
		for (int guard = 0; guard <= 4096; guard++) begin
			any = '0;
			for (int r = 0; r < side; r++) any |= front[r];
			if (any == '0) break;
			if (front[q.goal_row][q.goal_col]) begin
				hit = 1'b1;
				break;
			end
			for (int r = 0; r < 64; r++) grow[r] = '0;
			for (int r = 0; r < side; r++) begin
				seen[r] |= front[r];
				if (front[r] != '0) begin
					for (int k = 0; k < 8; k++) begin
						tr = r + STEP_DR[k];
						if (tr >= 0 && tr < side) begin
							w = (STEP_DC[k] >= 0) ? (front[r] << STEP_DC[k])
							                      : (front[r] >> (-STEP_DC[k]));
							grow[tr] |= w & mask;
						end
					end
				end
			end
			for (int r = 0; r < side; r++) front[r] = grow[r] & ~seen[r];
			if (levels != COUNT_MAX) levels++;
		end
		res.move_count = levels;
		res.found = hit;
		return res;
	endfunction

	// One query: optional idle gap, then hold valid until the transfer.
	task automatic send_query(in_t q);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
		      (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= q;
		do @(posedge clk); while (!in_ready);
		pending_answers.insert(pending_answers.size(), knight_distance(q, side_reg));
		n_sent++;
	endtask

	task automatic send_squares(int sc, int sr, int gc, int gr);
		in_t q;
		q.start_col = 6'(sc);
		q.start_row = 6'(sr);
		q.goal_col  = 6'(gc);
		q.goal_row  = 6'(gr);
		send_query(q);
	endtask

	// Wait for every answer, with extra slack for the engine afterwards.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_BOARD_SIDE) side_reg = data[6:0];
		@(posedge clk);
	endtask

	task automatic apb_check_side();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_BOARD_SIDE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[6:0] !== side_reg) begin
			$display("%0t board_side readback: expected %0d actual %0d",
			         $time, side_reg, prdata[6:0]);
			n_errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_side(int side);
		drain();
		apb_write(ADDR_BOARD_SIDE, 32'(side));
		apb_check_side();
	endtask

	// Reset value of 8: corners, neighbours, start on goal, each field off the board.
	task automatic test_default_board();
		apb_check_side();
		send_squares(0, 0, 0, 0);
		send_squares(0, 0, 7, 7);
		send_squares(7, 7, 0, 0);
		send_squares(0, 0, 1, 1);
		send_squares(3, 3, 4, 5);
		send_squares(0, 0, 0, 1);
		send_squares(8, 0, 0, 0);
		send_squares(0, 8, 0, 0);
		send_squares(0, 0, 8, 0);
		send_squares(0, 0, 0, 63);
		send_squares(63, 63, 63, 63);
	endtask

	// Boards too small for every square to be reached, and the empty board.
	task automatic test_tiny_boards();
		set_side(1);
		send_squares(0, 0, 0, 0);
		send_squares(0, 0, 1, 0);
		set_side(2);
		send_squares(0, 0, 1, 1);
		send_squares(1, 0, 1, 0);
		set_side(3);
		send_squares(0, 0, 1, 1);
		send_squares(0, 0, 2, 1);
		set_side(0);
		send_squares(0, 0, 0, 0);
	endtask

	// Oversized sides clamp to the full 64x64 board; the unused address is ignored.
	task automatic test_large_boards();
		set_side(127);
		send_squares(0, 0, 63, 63);
		send_squares(63, 0, 0, 63);
		set_side(64);
		apb_write(ADDR_UNUSED, 32'd5);
		apb_check_side();
		send_squares(0, 0, 62, 61);
		send_squares(63, 63, 63, 63);
		set_side(100);
		send_squares(32, 31, 0, 0);
	endtask

	// Random queries across a spread of board sides, mostly on the board.
	task automatic test_random_queries();
		int side;
		int batch;
		int lim;
		in_t q;
		for (int b = 0; b < 12; b++) begin
			case (b % 6)
				0: side = $urandom_range(1, 5);
				1: side = $urandom_range(5, 10);
				2: side = $urandom_range(10, 20);
				3: side = (b < 6) ? 64 : $urandom_range(65, 127);
				4: side = $urandom_range(20, 40);
				default: side = $urandom_range(0, 127);
			endcase
			set_side(side);
			lim = (side > 64) ? 64 : side;
			batch = (lim > 40) ? 4 : 11;
			for (int i = 0; i < batch; i++) begin
				if ($urandom_range(0, 9) < 2 || lim == 0) begin
					q = in_t'(24'($urandom()));
				end else begin
					q.start_col = 6'($urandom_range(0, lim - 1));
					q.start_row = 6'($urandom_range(0, lim - 1));
					q.goal_col  = 6'($urandom_range(0, lim - 1));
					q.goal_row  = 6'($urandom_range(0, lim - 1));
				end
				send_query(q);
			end
			// sender pause: once, after the fifth batch, let the engine run dry
			if (b == 4) begin
				drain();
			end
		end
	endtask

	// Receiver: mostly ready, with short and occasional long stalls.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// Every result transfer is checked against the oldest outstanding answer.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t unexpected result: actual %p", $time, out_data);
				n_errors++;
			end else begin
				want = pending_answers.pop_front();
				n_checked++;
				if (want.found) n_found++;
				else if (want.off_board) n_off++;
				else n_unreached++;
				if (out_data.move_count !== want.move_count) begin
					$display("%0t move_count: expected %0d actual %0d",
					         $time, want.move_count, out_data.move_count);
					n_errors++;
				end
				if (out_data.found !== want.found) begin
					$display("%0t found: expected %0b actual %0b",
					         $time, want.found, out_data.found);
					n_errors++;
				end
				if (out_data.off_board !== want.off_board) begin
					$display("%0t off_board: expected %0b actual %0b",
					         $time, want.off_board, out_data.off_board);
					n_errors++;
				end
			end
		end
	end

	initial begin
		n_errors = 0;
		n_checked = 0;
		n_sent = 0;
		n_found = 0;
		n_unreached = 0;
		n_off = 0;
		side_reg = 7'd8;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_board();
		test_tiny_boards();
		test_large_boards();
		test_random_queries();
		drain();
		repeat (20) @(posedge clk);
		if (pending_answers.size() != 0) begin
			$display("%0t %0d answers never arrived", $time, pending_answers.size());
			n_errors++;
		end
		$display("Sent %0d queries over sides 0..127, checked %0d results", n_sent, n_checked);
		$display("Reached %0d, unreachable %0d, off board %0d", n_found, n_unreached, n_off);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
hdl/kmbfs_pkg.sv
hdl/kmbfs_ctrl.sv
hdl/kmbfs_dp.sv
hdl/knight_min_moves_bfs_top.sv
tb/sv/tb_knight_min_moves_bfs_top.sv
